>>> hw/rtl/srrip_pkg.sv
// shared types, constants and helpers for the signature-based rrip replacement block
// no dependencies; srrip_if, srrip_seq and the top level depend on this package
`default_nettype none

package srrip_pkg;

  // geometry; the widths of the set and way fields follow from it
  localparam int unsigned NUM_SETS  = 2048;
  localparam int unsigned NUM_WAYS  = 16;
  localparam int unsigned SET_W     = $clog2(NUM_SETS);
  localparam int unsigned WAY_IDX_W = $clog2(NUM_WAYS);
  localparam int unsigned PC_W      = 64;
  localparam int unsigned LIMIT_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // defaults for the top-level parameters
  localparam int unsigned DEF_SIGNATURE_BITS = 14;
  localparam int unsigned DEF_COUNTER_BITS   = 4;
  localparam int unsigned DEF_VALUE_BITS     = 2;

  typedef enum logic {
    FUNC_QUERY  = 1'b0,
    FUNC_UPDATE = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAND_LOW  = 2'd0,
    CFG_BAND_MID  = 2'd1,
    CFG_BAND_HIGH = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW_RD,
    ST_SCAN,
    ST_AGE_WR,
    ST_HIT_WR,
    ST_TRAIN_RD,
    ST_TRAIN_WR,
    ST_SIG_RD,
    ST_FILL_WR
  } seq_state_e;

  typedef struct packed {
    logic [LIMIT_W-1:0] low;
    logic [LIMIT_W-1:0] mid;
    logic [LIMIT_W-1:0] high;
  } band_cfg_t;

  // per-way slot: {valid, referenced, signature, value}
  function automatic int unsigned slot_width(int unsigned signature_w, int unsigned value_bits);
    return value_bits + signature_w + 2;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/srrip_if.sv
// valid/ready channel interfaces for request and response items
// depends on srrip_pkg for field widths
`default_nettype none

interface srrip_req_if;
  logic                            valid;
  logic                            ready;
  logic                            func;
  logic [srrip_pkg::SET_W-1:0]     set_index;
  logic [srrip_pkg::WAY_IDX_W-1:0] way_index;
  logic                            was_hit;
  logic [srrip_pkg::PC_W-1:0]      program_counter;

  modport source (output valid, func, set_index, way_index, was_hit, program_counter,
                  input ready);
  modport sink (input valid, func, set_index, way_index, was_hit, program_counter,
                output ready);
endinterface

interface srrip_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [srrip_pkg::WAY_IDX_W-1:0] victim_way;

  modport source (output valid, victim_way, input ready);
  modport sink (input valid, victim_way, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/srrip_ram.sv
// single-port ram with registered read data, used for the set rows and the counter table
// no package dependencies
`default_nettype none

module srrip_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  output      logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/srrip_seq.sv
// sequencer: clearing pass, one-way-per-cycle victim scan, hit update, counter training and fill
// depends on srrip_pkg, srrip_if; drives the row ram and the counter ram
`default_nettype none

module srrip_seq #(
  parameter int unsigned SIGNATURE_BITS = srrip_pkg::DEF_SIGNATURE_BITS,
  parameter int unsigned COUNTER_BITS   = srrip_pkg::DEF_COUNTER_BITS,
  parameter int unsigned VALUE_BITS     = srrip_pkg::DEF_VALUE_BITS,
  parameter int unsigned ROW_W          = srrip_pkg::NUM_WAYS *
                                          srrip_pkg::slot_width(SIGNATURE_BITS, VALUE_BITS)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire srrip_pkg::band_cfg_t        band_i,
  srrip_req_if.sink                        req,
  srrip_rsp_if.source                      rsp,
  output      logic                        row_we_o,
  output      logic                        row_re_o,
  output      logic [srrip_pkg::SET_W-1:0] row_addr_o,
  output      logic [ROW_W-1:0]            row_wdata_o,
  input  wire logic [ROW_W-1:0]            row_rdata_i,
  output      logic                        ctr_we_o,
  output      logic                        ctr_re_o,
  output      logic [SIGNATURE_BITS-1:0]   ctr_addr_o,
  output      logic [COUNTER_BITS-1:0]     ctr_wdata_o,
  input  wire logic [COUNTER_BITS-1:0]     ctr_rdata_i
);

  import srrip_pkg::*;

  localparam int unsigned SLOT_W      = slot_width(SIGNATURE_BITS, VALUE_BITS);
  localparam int unsigned SIG_LSB     = VALUE_BITS;
  localparam int unsigned REF_BIT     = VALUE_BITS + SIGNATURE_BITS;
  localparam int unsigned VLD_BIT     = REF_BIT + 1;
  localparam int unsigned SIG_ENTRIES = 1 << SIGNATURE_BITS;
  localparam int unsigned CLR_LEN     = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
  localparam int unsigned CLR_W       = $clog2(CLR_LEN);
  localparam int unsigned CMP_W       = 8;

  localparam logic [VALUE_BITS-1:0] VAL_MAX = '1;
  localparam logic [VALUE_BITS-1:0] VAL_M1  = VALUE_BITS'((1 << VALUE_BITS) - 2);
  localparam logic [VALUE_BITS-1:0] VAL_M2  =
    (VALUE_BITS > 1) ? VALUE_BITS'((1 << VALUE_BITS) - 3) : '0;
  localparam logic [COUNTER_BITS-1:0] CTR_MAX  = '1;
  localparam logic [COUNTER_BITS-1:0] CTR_INIT = COUNTER_BITS'(1 << (COUNTER_BITS - 1));

  seq_state_e state_q, state_d;

  logic                      func_q, func_d;
  logic [SET_W-1:0]          set_q, set_d;
  logic [WAY_IDX_W-1:0]      way_q, way_d;
  logic                      hit_q, hit_d;
  logic [SIGNATURE_BITS-1:0] sig_q, sig_d;
  logic [WAY_IDX_W-1:0]      scan_q, scan_d;
  logic [VALUE_BITS-1:0]     top_q, top_d;
  logic [WAY_IDX_W-1:0]      pick_q, pick_d;
  logic [CLR_W-1:0]          clr_q, clr_d;
  logic                      out_valid_q, out_valid_d;
  logic [WAY_IDX_W-1:0]      victim_q, victim_d;

  logic [SLOT_W-1:0]         old_slot;
  logic [SIGNATURE_BITS-1:0] old_sig;
  logic [VALUE_BITS-1:0]     scan_val;
  logic [VALUE_BITS-1:0]     delta;
  logic [VALUE_BITS-1:0]     ins_val;
  logic [ROW_W-1:0]          clear_row;
  logic [ROW_W-1:0]          aged_row;
  logic [SLOT_W-1:0]         hit_slot;
  logic [SLOT_W-1:0]         fill_slot;
  logic                      can_finish;

  assign old_slot   = row_rdata_i[way_q*SLOT_W +: SLOT_W];
  assign old_sig    = old_slot[SIG_LSB +: SIGNATURE_BITS];
  assign scan_val   = row_rdata_i[scan_q*SLOT_W +: VALUE_BITS];
  assign delta      = VAL_MAX - top_q;
  assign can_finish = !out_valid_q || rsp.ready;

  // insertion value from the counter band of the new signature
  always_comb begin
    if (CMP_W'(ctr_rdata_i) < CMP_W'(band_i.low)) begin
      ins_val = VAL_MAX;
    end else if (CMP_W'(ctr_rdata_i) < CMP_W'(band_i.mid)) begin
      ins_val = VAL_M1;
    end else if (CMP_W'(ctr_rdata_i) < CMP_W'(band_i.high)) begin
      ins_val = VAL_M2;
    end else begin
      ins_val = '0;
    end
  end

  always_comb begin
    clear_row = '0;
    aged_row  = row_rdata_i;
    for (int w = 0; w < NUM_WAYS; w++) begin
      clear_row[w*SLOT_W +: VALUE_BITS] = VAL_MAX;
      aged_row[w*SLOT_W +: VALUE_BITS]  = row_rdata_i[w*SLOT_W +: VALUE_BITS] + delta;
    end
  end

  always_comb begin
    hit_slot                   = old_slot;
    hit_slot[VALUE_BITS-1:0]   = '0;
    hit_slot[REF_BIT]          = 1'b1;
    fill_slot                  = {1'b1, 1'b0, sig_q, ins_val};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    set_q    <= set_d;
    way_q    <= way_d;
    hit_q    <= hit_d;
    sig_q    <= sig_d;
    scan_q   <= scan_d;
    top_q    <= top_d;
    pick_q   <= pick_d;
    victim_q <= victim_d;
  end

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    set_d       = set_q;
    way_d       = way_q;
    hit_d       = hit_q;
    sig_d       = sig_q;
    scan_d      = scan_q;
    top_d       = top_q;
    pick_d      = pick_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !rsp.ready;
    victim_d    = victim_q;

    req.ready   = 1'b0;
    row_we_o    = 1'b0;
    row_re_o    = 1'b0;
    row_addr_o  = set_q;
    row_wdata_o = row_rdata_i;
    ctr_we_o    = 1'b0;
    ctr_re_o    = 1'b0;
    ctr_addr_o  = sig_q;
    ctr_wdata_o = ctr_rdata_i;

    case (state_q)
      ST_CLEAR: begin
        row_addr_o  = clr_q[SET_W-1:0];
        row_wdata_o = clear_row;
        row_we_o    = {1'b0, clr_q} < (CLR_W + 1)'(NUM_SETS);
        ctr_addr_o  = clr_q[SIGNATURE_BITS-1:0];
        ctr_wdata_o = CTR_INIT;
        ctr_we_o    = {1'b0, clr_q} < (CLR_W + 1)'(SIG_ENTRIES);
        clr_d       = clr_q + 1'b1;
        if (clr_q == CLR_W'(CLR_LEN - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          func_d  = req.func;
          set_d   = req.set_index;
          way_d   = req.way_index;
          hit_d   = req.was_hit;
          sig_d   = req.program_counter[2 +: SIGNATURE_BITS];
          state_d = ST_ROW_RD;
        end
      end
      ST_ROW_RD: begin
        row_re_o = 1'b1;
        scan_d   = '0;
        if (func_q == FUNC_QUERY) begin
          state_d = ST_SCAN;
        end else if (hit_q) begin
          state_d = ST_HIT_WR;
        end else begin
          state_d = ST_TRAIN_RD;
        end
      end
      ST_SCAN: begin
        // running maximum, first way holding it wins
        if (scan_q == '0 || scan_val > top_q) begin
          top_d  = scan_val;
          pick_d = scan_q;
        end
        scan_d = scan_q + 1'b1;
        if (scan_q == WAY_IDX_W'(NUM_WAYS - 1)) begin
          state_d = ST_AGE_WR;
        end
      end
      ST_AGE_WR: begin
        row_wdata_o = aged_row;
        if (can_finish) begin
          row_we_o    = 1'b1;
          out_valid_d = 1'b1;
          victim_d    = pick_q;
          state_d     = ST_IDLE;
        end
      end
      ST_HIT_WR: begin
        row_wdata_o                        = row_rdata_i;
        row_wdata_o[way_q*SLOT_W +: SLOT_W] = hit_slot;
        if (can_finish) begin
          row_we_o    = 1'b1;
          out_valid_d = 1'b1;
          victim_d    = '0;
          state_d     = ST_IDLE;
        end
      end
      ST_TRAIN_RD: begin
        ctr_re_o = 1'b1;
        if (old_slot[VLD_BIT]) begin
          ctr_addr_o = old_sig;
          state_d    = ST_TRAIN_WR;
        end else begin
          // nothing to train, fetch the new signature's counter right away
          ctr_addr_o = sig_q;
          state_d    = ST_FILL_WR;
        end
      end
      ST_TRAIN_WR: begin
        ctr_we_o   = 1'b1;
        ctr_addr_o = old_sig;
        if (old_slot[REF_BIT]) begin
          ctr_wdata_o = (ctr_rdata_i == CTR_MAX) ? ctr_rdata_i : ctr_rdata_i + 1'b1;
        end else begin
          ctr_wdata_o = (ctr_rdata_i == '0) ? ctr_rdata_i : ctr_rdata_i - 1'b1;
        end
        state_d = ST_SIG_RD;
      end
      ST_SIG_RD: begin
        ctr_re_o   = 1'b1;
        ctr_addr_o = sig_q;
        state_d    = ST_FILL_WR;
      end
      ST_FILL_WR: begin
        row_wdata_o                        = row_rdata_i;
        row_wdata_o[way_q*SLOT_W +: SLOT_W] = fill_slot;
        if (can_finish) begin
          row_we_o    = 1'b1;
          out_valid_d = 1'b1;
          victim_d    = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rsp.valid      = out_valid_q;
  assign rsp.victim_way = victim_q;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !req.ready)
    else $error("sequencer ready right after accepting an item");

  a_result_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_AGE_WR || $past(state_q) == ST_HIT_WR ||
                            $past(state_q) == ST_FILL_WR))
    else $error("result raised outside a final write state");

  a_single_ram_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_we_o && ctr_we_o) |-> state_q == ST_CLEAR)
    else $error("row and counter rams written together outside clearing");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (!req.ready && !out_valid_q))
    else $error("item traffic during clearing pass");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/ship_rrip_cache_replacement.sv
// top level: band limit registers, set row ram, signature counter ram and the sequencer
// depends on srrip_pkg, srrip_if, srrip_ram, srrip_seq
`default_nettype none

// Signature-based RRIP replacement for a 2048-set, 16-way cache. Each request item is a
// victim query or an update; every item returns exactly one response item (the victim way
// for a query, zero for an update). One item is worked on at a time by a small sequencer
// around single-port memories: a set row (all ways' values, signatures and flags) and the
// signature counter table. A victim query scans the row one way per cycle through a single
// compare unit, then ages the row and writes it back. A hit update rewrites its slot; a
// miss trains the evicted block's counter if that block is valid, reads the counter of
// the new signature and fills the slot. After reset a clearing pass over the first
// max(NUM_SETS, 2**SIGNATURE_BITS) addresses initializes both memories before the first
// request item is taken. Band limit writes are accepted at any time.
module ship_rrip_cache_replacement #(
  parameter int unsigned SIGNATURE_BITS = srrip_pkg::DEF_SIGNATURE_BITS,
  parameter int unsigned COUNTER_BITS   = srrip_pkg::DEF_COUNTER_BITS,
  parameter int unsigned VALUE_BITS     = srrip_pkg::DEF_VALUE_BITS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [srrip_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [srrip_pkg::LIMIT_W-1:0]   cfg_data_i,
  srrip_req_if.sink                            req_i,
  srrip_rsp_if.source                          rsp_o
);

  import srrip_pkg::*;

  localparam int unsigned ROW_W     = NUM_WAYS * slot_width(SIGNATURE_BITS, VALUE_BITS);
  localparam int unsigned CTR_MAX_I = (1 << COUNTER_BITS) - 1;

  localparam logic [LIMIT_W-1:0] LOW_RST  = LIMIT_W'((CTR_MAX_I >> 2) + 1);
  localparam logic [LIMIT_W-1:0] MID_RST  = LIMIT_W'((CTR_MAX_I >> 1) + 1);
  localparam logic [LIMIT_W-1:0] HIGH_RST = LIMIT_W'(((CTR_MAX_I * 3) >> 2) + 1);

  band_cfg_t band_q, band_d;

  logic                      row_we;
  logic                      row_re;
  logic [SET_W-1:0]          row_addr;
  logic [ROW_W-1:0]          row_wdata;
  logic [ROW_W-1:0]          row_rdata;
  logic                      ctr_we;
  logic                      ctr_re;
  logic [SIGNATURE_BITS-1:0] ctr_addr;
  logic [COUNTER_BITS-1:0]   ctr_wdata;
  logic [COUNTER_BITS-1:0]   ctr_rdata;

  always_comb begin
    band_d = band_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BAND_LOW:  band_d.low  = cfg_data_i;
        CFG_BAND_MID:  band_d.mid  = cfg_data_i;
        CFG_BAND_HIGH: band_d.high = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q <= '{low: LOW_RST, mid: MID_RST, high: HIGH_RST};
    end else begin
      band_q <= band_d;
    end
  end

  srrip_ram #(
    .DATA_W (ROW_W),
    .DEPTH  (NUM_SETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .re_i    (row_re),
    .addr_i  (row_addr),
    .wdata_i (row_wdata),
    .rdata_o (row_rdata)
  );

  srrip_ram #(
    .DATA_W (COUNTER_BITS),
    .DEPTH  (1 << SIGNATURE_BITS)
  ) u_ctr_ram (
    .clk_i   (clk_i),
    .we_i    (ctr_we),
    .re_i    (ctr_re),
    .addr_i  (ctr_addr),
    .wdata_i (ctr_wdata),
    .rdata_o (ctr_rdata)
  );

  srrip_seq #(
    .SIGNATURE_BITS (SIGNATURE_BITS),
    .COUNTER_BITS   (COUNTER_BITS),
    .VALUE_BITS     (VALUE_BITS),
    .ROW_W          (ROW_W)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .band_i      (band_q),
    .req         (req_i),
    .rsp         (rsp_o),
    .row_we_o    (row_we),
    .row_re_o    (row_re),
    .row_addr_o  (row_addr),
    .row_wdata_o (row_wdata),
    .row_rdata_i (row_rdata),
    .ctr_we_o    (ctr_we),
    .ctr_re_o    (ctr_re),
    .ctr_addr_o  (ctr_addr),
    .ctr_wdata_o (ctr_wdata),
    .ctr_rdata_i (ctr_rdata)
  );

endmodule

`default_nettype wire

>>> tb/ship_rrip_cache_replacement_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for ship_rrip_cache_replacement: victim queries and replacement updates
// checked against a local model of the per-set re-reference values and signature counters
// depends on srrip_pkg, srrip_if and the rtl of the block

module ship_rrip_cache_replacement_tb;
  import srrip_pkg::*;

  localparam int unsigned SIG_W   = DEF_SIGNATURE_BITS;
  localparam int unsigned CTR_W   = DEF_COUNTER_BITS;
  localparam int unsigned VAL_W   = DEF_VALUE_BITS;
  localparam int unsigned BLOCKS  = NUM_SETS * NUM_WAYS;
  localparam int unsigned VAL_MAX = (1 << VAL_W) - 1;
  localparam int unsigned CTR_MAX = (1 << CTR_W) - 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic ACC_HIT  = 1'b1;
  localparam logic ACC_MISS = 1'b0;

  typedef struct {
    func_e              func;
    logic [SET_W-1:0]   set_index;
    logic [WAY_IDX_W-1:0] way_index;
    logic               was_hit;
    logic [PC_W-1:0]    pc;
  } access_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [LIMIT_W-1:0]   cfg_data_i;

  srrip_req_if req_bus ();
  srrip_rsp_if rsp_bus ();

  ship_rrip_cache_replacement uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_bus.sink),
    .rsp_o      (rsp_bus.source)
  );

  // model of the replacement state
  logic [VAL_W-1:0]   rrpv_mem      [BLOCKS];
  logic [CTR_W-1:0]   sig_ctr_mem   [1 << SIG_W];
  logic [SIG_W-1:0]   blk_sig_mem   [BLOCKS];
  logic               blk_ref_mem   [BLOCKS];
  logic               blk_valid_mem [BLOCKS];
  logic [LIMIT_W-1:0] band_low, band_mid, band_high;

  access_t              access_q [$];
  logic [WAY_IDX_W-1:0] victim_q [$];

  int unsigned error_count = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  bit          req_taken = 1'b0;
  bit          idle_off = 1'b0;

  logic [SET_W-1:0] set_pool [6];
  logic [SIG_W-1:0] sig_pool [8];

  task automatic report_error(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic void reset_model();
    for (int i = 0; i < BLOCKS; i++) begin
      rrpv_mem[i]      = VAL_W'(VAL_MAX);
      blk_sig_mem[i]   = '0;
      blk_ref_mem[i]   = 1'b0;
      blk_valid_mem[i] = 1'b0;
    end
    for (int i = 0; i < (1 << SIG_W); i++) sig_ctr_mem[i] = CTR_W'((CTR_MAX >> 1) + 1);
    band_low  = LIMIT_W'((CTR_MAX >> 2) + 1);
    band_mid  = LIMIT_W'((CTR_MAX >> 1) + 1);
    band_high = LIMIT_W'(((CTR_MAX * 3) >> 2) + 1);
  endfunction

  // applies one access to the model and returns the way the block must report
  function automatic logic [WAY_IDX_W-1:0] replace_step(access_t a);
    int unsigned base, idx;
    logic [VAL_W-1:0] top;
    logic [SIG_W-1:0] sig, old_sig;
    logic [CTR_W-1:0] ctr;
    logic [WAY_IDX_W-1:0] pick;
    base = a.set_index * NUM_WAYS;
    pick = '0;
    if (a.func == FUNC_QUERY) begin
      top = '0;
      for (int w = 0; w < NUM_WAYS; w++)
        if (rrpv_mem[base + w] > top) top = rrpv_mem[base + w];
      // aging in one go: lift the set until its oldest way reaches the maximum
      if (top < VAL_MAX)
        for (int w = 0; w < NUM_WAYS; w++)
          rrpv_mem[base + w] = rrpv_mem[base + w] + VAL_W'(VAL_MAX - top);
      for (int w = NUM_WAYS - 1; w >= 0; w--)
        if (rrpv_mem[base + w] == VAL_MAX) pick = WAY_IDX_W'(w);
      return pick;
    end
    idx = base + a.way_index;
    if (a.was_hit) begin
      rrpv_mem[idx]    = '0;
      blk_ref_mem[idx] = 1'b1;
      return pick;
    end
    // train the evicted block's counter
    if (blk_valid_mem[idx]) begin
      old_sig = blk_sig_mem[idx];
      if (blk_ref_mem[idx]) begin
        if (sig_ctr_mem[old_sig] < CTR_MAX) sig_ctr_mem[old_sig]++;
      end else begin
        if (sig_ctr_mem[old_sig] > 0) sig_ctr_mem[old_sig]--;
      end
    end
    sig = a.pc[2 +: SIG_W];
    ctr = sig_ctr_mem[sig];
    if (ctr < band_low) rrpv_mem[idx] = VAL_W'(VAL_MAX);
    else if (ctr < band_mid) rrpv_mem[idx] = (VAL_MAX > 1) ? VAL_W'(VAL_MAX - 1) : '0;
    else if (ctr < band_high) rrpv_mem[idx] = (VAL_MAX > 2) ? VAL_W'(VAL_MAX - 2) : '0;
    else rrpv_mem[idx] = '0;
    blk_sig_mem[idx]   = sig;
    blk_ref_mem[idx]   = 1'b0;
    blk_valid_mem[idx] = 1'b1;
    return pick;
  endfunction

  function automatic int unsigned draw_gap();
    int unsigned r;
    if (idle_off) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PC_W-1:0] rand_pc();
    return {$urandom(), $urandom()};
  endfunction

  task automatic add_access(func_e f, logic [SET_W-1:0] s, logic [WAY_IDX_W-1:0] w,
                            logic h, logic [PC_W-1:0] pc);
    access_t a;
    a.func = f;
    a.set_index = s;
    a.way_index = w;
    a.was_hit = h;
    a.pc = pc;
    access_q.push_back(a);
  endtask

  // mostly fill episodes on six hot sets; odd pool signatures are mostly reused, even ones rarely
  task automatic add_random(int unsigned count);
    int unsigned target, k;
    logic [SET_W-1:0] s;
    logic [WAY_IDX_W-1:0] w;
    logic [PC_W-1:0] pc;
    target = access_q.size() + count;
    while (access_q.size() < target) begin
      if ($urandom_range(0, 9) == 0) begin
        add_access(func_e'($urandom_range(0, 1)), SET_W'($urandom()), WAY_IDX_W'($urandom()),
                   1'($urandom()), rand_pc());
      end else begin
        s = set_pool[$urandom_range(0, 5)];
        k = $urandom_range(0, 7);
        w = WAY_IDX_W'($urandom_range(0, NUM_WAYS - 1));
        pc = rand_pc();
        pc[2 +: SIG_W] = sig_pool[k];
        if ($urandom_range(0, 1)) add_access(FUNC_QUERY, s, '0, 1'($urandom()), rand_pc());
        add_access(FUNC_UPDATE, s, w, ACC_MISS, pc);
        if (k[0] ? ($urandom_range(0, 9) < 9) : ($urandom_range(0, 9) == 0))
          add_access(FUNC_UPDATE, s, w, ACC_HIT, rand_pc());
      end
    end
  endtask

  task automatic write_band(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  task automatic set_bands(logic [LIMIT_W-1:0] lo, logic [LIMIT_W-1:0] mid,
                           logic [LIMIT_W-1:0] hi);
    write_band(CFG_BAND_LOW, lo);
    write_band(CFG_BAND_MID, mid);
    write_band(CFG_BAND_HIGH, hi);
  endtask

  // checked at the rising edge, where the driver's last update is already visible
  task automatic wait_drained();
    while (access_q.size() != 0 || req_bus.valid || victim_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("ship_rrip_cache_replacement_tb failed");
    $finish;
  end

  // request driver
  always @(negedge clk_i) begin : drive_req
    access_t nxt;
    if (rst_ni && (!req_bus.valid || req_taken)) begin
      if (send_gap > 0) begin
        req_bus.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (access_q.size() > 0) begin
        nxt = access_q.pop_front();
        req_bus.func            <= nxt.func;
        req_bus.set_index       <= nxt.set_index;
        req_bus.way_index       <= nxt.way_index;
        req_bus.was_hit         <= nxt.was_hit;
        req_bus.program_counter <= nxt.pc;
        req_bus.valid           <= 1'b1;
        send_gap <= draw_gap();
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // response back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        rsp_bus.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        rsp_bus.ready <= 1'b1;
        if ($urandom_range(0, 7) == 0) stall_left <= draw_gap();
      end
    end
  end

  // monitor: band writes, accepted requests and responses
  always @(posedge clk_i) begin : observe
    access_t a;
    logic [WAY_IDX_W-1:0] want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BAND_LOW:  band_low  = cfg_data_i;
          CFG_BAND_MID:  band_mid  = cfg_data_i;
          CFG_BAND_HIGH: band_high = cfg_data_i;
          default: ;
        endcase
      end
      req_taken = req_bus.valid && req_bus.ready;
      if (req_taken) begin
        a.func      = func_e'(req_bus.func);
        a.set_index = req_bus.set_index;
        a.way_index = req_bus.way_index;
        a.was_hit   = req_bus.was_hit;
        a.pc        = req_bus.program_counter;
        victim_q.push_back(replace_step(a));
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (victim_q.size() == 0) begin
          report_error($sformatf("response item with none pending, victim_way %0d",
                                 rsp_bus.victim_way));
        end else begin
          want = victim_q.pop_front();
          if (rsp_bus.victim_way !== want)
            report_error($sformatf("victim_way %0d, expected %0d", rsp_bus.victim_way, want));
        end
      end
    end
  end

  initial begin
    reset_model();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    req_bus.valid = 1'b0;
    req_bus.func = FUNC_QUERY;
    req_bus.set_index = '0;
    req_bus.way_index = '0;
    req_bus.was_hit = 1'b0;
    req_bus.program_counter = '0;
    rsp_bus.ready = 1'b0;
    set_pool[0] = '0;
    set_pool[1] = '1;
    for (int i = 2; i < 6; i++) set_pool[i] = SET_W'($urandom());
    sig_pool[0] = '0;
    sig_pool[1] = '1;
    for (int i = 2; i < 8; i++) sig_pool[i] = SIG_W'($urandom());
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // fresh sets, hit and fill paths, counter training both ways
    add_access(FUNC_QUERY, '0, '0, ACC_MISS, '0);
    add_access(FUNC_QUERY, '1, '1, ACC_HIT, '1);
    add_access(FUNC_UPDATE, '0, '0, ACC_HIT, '1);
    add_access(FUNC_QUERY, '0, '0, ACC_MISS, '0);
    add_access(FUNC_UPDATE, '0, '1, ACC_MISS, '1);
    add_access(FUNC_UPDATE, '0, '1, ACC_MISS, '0);
    add_access(FUNC_UPDATE, '0, '1, ACC_HIT, rand_pc());
    add_access(FUNC_UPDATE, '0, '1, ACC_MISS, '0);
    // every way of one set at zero, then a query must age the whole set
    for (int w = 0; w < NUM_WAYS; w++)
      add_access(FUNC_UPDATE, SET_W'(3), WAY_IDX_W'(w), ACC_HIT, rand_pc());
    add_access(FUNC_QUERY, SET_W'(3), '0, ACC_MISS, '0);
    add_random(200);
    wait_drained();

    for (int ph = 1; ph <= 5; ph++) begin
      idle_off = (ph == 2);
      case (ph)
        1: set_bands('0, '0, '0);
        2: set_bands('1, '1, '1);
        3: set_bands(4'd3, 4'd7, 4'd11);
        4: begin
          set_bands(4'd12, 4'd4, 4'd8);
          write_band(CFG_SPARE, '1);
        end
        default: set_bands(LIMIT_W'($urandom()), LIMIT_W'($urandom()), LIMIT_W'($urandom()));
      endcase
      add_random(200);
      wait_drained();
    end

    repeat (50) @(negedge clk_i);
    if (error_count == 0) begin
      $display("ship_rrip_cache_replacement_tb passed");
    end else begin
      $display("ship_rrip_cache_replacement_tb failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/srrip_pkg.sv
hw/rtl/srrip_if.sv
hw/rtl/srrip_ram.sv
hw/rtl/srrip_seq.sv
hw/rtl/ship_rrip_cache_replacement.sv
tb/ship_rrip_cache_replacement_tb.sv
